// File: rtl/core/tsb_pkg.sv
// Shared types, constants and the fixed base colour table of the tile sprite blitter.
// Used by every module under rtl/core; depends on nothing.
package tsb_pkg;

   localparam int CELL_SIZE_DEF     = 8;
   localparam int CELLS_PER_ROW_DEF = 16;
   localparam int CANVAS_WIDTH_DEF  = 128;
   localparam int CANVAS_HEIGHT_DEF = 128;
   localparam int PALETTE_SIZE_DEF  = 16;

   localparam int SHEET_DEPTH  = 16384;
   localparam int SHEET_ADDR_W = 14;
   localparam int INDEX_W      = 4;
   localparam int PAL_DEPTH    = 16;
   localparam int COORD_W      = 7;
   localparam int RGB_W        = 24;

   typedef enum logic [1:0] {
      OP_LOAD      = 2'd0,
      OP_PAL_SET   = 2'd1,
      OP_PAL_RESET = 2'd2,
      OP_BLIT      = 2'd3
   } op_type;

   typedef struct packed {
      op_type                    op;
      logic [SHEET_ADDR_W-1:0]   sheet_addr;
      logic [INDEX_W-1:0]        sheet_pixel;
      logic [INDEX_W-1:0]        pal_entry;
      logic [INDEX_W-1:0]        pal_source;
      logic [7:0]                cell_index;
      logic signed [15:0]        dest_x;
      logic signed [15:0]        dest_y;
      logic                      use_colour;
      logic [INDEX_W-1:0]        override_colour;
      logic                      mirror_x;
      logic                      mirror_y;
   } req_type;

   typedef struct packed {
      logic [COORD_W-1:0] pixel_x;
      logic [COORD_W-1:0] pixel_y;
      logic [RGB_W-1:0]   pixel_rgb;
      logic               last;
   } rsp_type;

   // Per-cycle result of the coordinate unit
   typedef struct packed {
      logic                    row_ok;
      logic                    on_canvas;
      logic [SHEET_ADDR_W-1:0] addr;
      logic [COORD_W-1:0]      px;
      logic [COORD_W-1:0]      py;
   } walk_status_type;

   function automatic logic [RGB_W-1:0] base_rgb(input logic [INDEX_W-1:0] idx);
      logic [RGB_W-1:0] rgb;
      case (idx)
         4'd0:    rgb = 24'h000000;
         4'd1:    rgb = 24'h1d2b53;
         4'd2:    rgb = 24'h7e2553;
         4'd3:    rgb = 24'h008751;
         4'd4:    rgb = 24'hab5236;
         4'd5:    rgb = 24'h5f574f;
         4'd6:    rgb = 24'hc2c3c7;
         4'd7:    rgb = 24'hfff1e8;
         4'd8:    rgb = 24'hff004d;
         4'd9:    rgb = 24'hffa300;
         4'd10:   rgb = 24'hffec27;
         4'd11:   rgb = 24'h00e436;
         4'd12:   rgb = 24'h29adff;
         4'd13:   rgb = 24'h83769c;
         4'd14:   rgb = 24'hff77a8;
         default: rgb = 24'hffccaa;
      endcase
      return rgb;
   endfunction

endpackage

// File: rtl/core/tsb_sheet_ram.sv
// Sprite sheet storage: one write port, one registered read port.
// Depends on tsb_pkg for depth and widths.
module tsb_sheet_ram (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [tsb_pkg::SHEET_ADDR_W-1:0] wr_addr,
   input  logic [tsb_pkg::INDEX_W-1:0]      wr_data,
   input  logic                             rd_en,
   input  logic [tsb_pkg::SHEET_ADDR_W-1:0] rd_addr,
   output logic [tsb_pkg::INDEX_W-1:0]      rd_data
);

   logic [tsb_pkg::INDEX_W-1:0] mem [tsb_pkg::SHEET_DEPTH];
   logic [tsb_pkg::INDEX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/tsb_palette.sv
// Live palette registers and the index-to-RGB lookup through the base table.
// Depends on tsb_pkg for widths and base_rgb.
module tsb_palette #(
   parameter int PALETTE_SIZE = tsb_pkg::PALETTE_SIZE_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          set_en,
   input  logic                          restore_en,
   input  logic [tsb_pkg::INDEX_W-1:0]   entry,
   input  logic [tsb_pkg::INDEX_W-1:0]   source,
   input  logic [tsb_pkg::INDEX_W-1:0]   lookup,
   output logic [tsb_pkg::RGB_W-1:0]     rgb
);

   logic [tsb_pkg::INDEX_W-1:0] pal_ff [tsb_pkg::PAL_DEPTH];
   logic                        in_range;

   assign in_range = ({1'b0, entry} < (tsb_pkg::INDEX_W+1)'(PALETTE_SIZE)) &&
                     ({1'b0, source} < (tsb_pkg::INDEX_W+1)'(PALETTE_SIZE));

   always_ff @(posedge clock) begin
      if (reset || restore_en) begin
         for (int i = 0; i < tsb_pkg::PAL_DEPTH; i++) begin
            pal_ff[i] <= tsb_pkg::INDEX_W'(i);
         end
      end else if (set_en && in_range) begin
         pal_ff[entry] <= source;
      end
   end

   assign rgb = tsb_pkg::base_rgb(pal_ff[lookup]);

endmodule

// File: rtl/core/tsb_walk_unit.sv
// Coordinate unit shared by every step of a blit: sheet address, destination
// position and clipping for one cell pixel. Depends on tsb_pkg.
module tsb_walk_unit #(
   parameter int CELL_SIZE     = tsb_pkg::CELL_SIZE_DEF,
   parameter int CELLS_PER_ROW = tsb_pkg::CELLS_PER_ROW_DEF,
   parameter int CANVAS_WIDTH  = tsb_pkg::CANVAS_WIDTH_DEF,
   parameter int CANVAS_HEIGHT = tsb_pkg::CANVAS_HEIGHT_DEF,
   localparam int CNT_W   = $clog2(CELL_SIZE),
   localparam int SHEET_W = CELL_SIZE * CELLS_PER_ROW,
   localparam int SX_W    = $clog2(SHEET_W),
   localparam int SY_W    = $clog2(256 * CELL_SIZE)
) (
   input  logic [SY_W-1:0]             sy_base,
   input  logic [SX_W-1:0]             sx_base,
   input  logic [CNT_W-1:0]            row,
   input  logic [CNT_W-1:0]            col,
   input  logic                        mirror_x,
   input  logic                        mirror_y,
   input  logic [15:0]                 dest_x,
   input  logic [15:0]                 dest_y,
   output tsb_pkg::walk_status_type    status
);

   localparam int SHEET_H = tsb_pkg::SHEET_DEPTH / SHEET_W;

   logic [SY_W-1:0]  sy;
   logic [SX_W-1:0]  sx;
   logic [CNT_W-1:0] off_x;
   logic [CNT_W-1:0] off_y;
   logic [16:0]      px;
   logic [16:0]      py;
   logic [31:0]      addr_wide;

   always_comb begin
      sy    = sy_base + SY_W'(row);
      sx    = sx_base + SX_W'(col);
      off_x = mirror_x ? (CNT_W'(CELL_SIZE - 1) - col) : col;
      off_y = mirror_y ? (CNT_W'(CELL_SIZE - 1) - row) : row;
      // sign-extend the destination, offsets are always non-negative
      px = {dest_x[15], dest_x} + 17'(off_x);
      py = {dest_y[15], dest_y} + 17'(off_y);
      addr_wide = 32'(sy) * 32'(SHEET_W) + 32'(sx);

      status.row_ok    = 32'(sy) < 32'(SHEET_H);
      status.on_canvas = !px[16] && !py[16] &&
                         (px < 17'(CANVAS_WIDTH)) && (py < 17'(CANVAS_HEIGHT));
      status.addr      = addr_wide[tsb_pkg::SHEET_ADDR_W-1:0];
      status.px        = px[tsb_pkg::COORD_W-1:0];
      status.py        = py[tsb_pkg::COORD_W-1:0];
   end

endmodule

// File: rtl/core/tile_sprite_blitter.sv
// Tile sprite blitter top level: sequencer, sheet, palette and output staging.
// Load and palette requests are applied as they are accepted. A blit splits the cell
// number into column and row (ST_DIV), forms the base (ST_BASE), walks every cell pixel
// with one sheet read each (ST_WALK) and drains the output stages (ST_DRAIN); the walk
// and drain hold while the result side stalls. Synchronous reset clears control state and
// sets the palette to identity; the sheet is not cleared.
module tile_sprite_blitter #(
   parameter int CELL_SIZE     = tsb_pkg::CELL_SIZE_DEF,
   parameter int CELLS_PER_ROW = tsb_pkg::CELLS_PER_ROW_DEF,
   parameter int CANVAS_WIDTH  = tsb_pkg::CANVAS_WIDTH_DEF,
   parameter int CANVAS_HEIGHT = tsb_pkg::CANVAS_HEIGHT_DEF,
   parameter int PALETTE_SIZE  = tsb_pkg::PALETTE_SIZE_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tsb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tsb_pkg::rsp_type rsp_data
);

   localparam int CNT_W     = $clog2(CELL_SIZE);
   localparam int SHEET_W   = CELL_SIZE * CELLS_PER_ROW;
   localparam int SX_W      = $clog2(SHEET_W);
   localparam int SY_W      = $clog2(256 * CELL_SIZE);
   localparam int DIV_SHIFT = 16;
   localparam int DIV_MULT  = ((1 << DIV_SHIFT) + CELLS_PER_ROW - 1) / CELLS_PER_ROW;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_BASE,
      ST_WALK,
      ST_DRAIN
   } state_type;

   state_type                    state_ff;
   logic [7:0]                   dvd_ff;
   logic [7:0]                   quo_ff;
   logic [6:0]                   rem_ff;
   logic [SY_W-1:0]              sy_base_ff;
   logic [SX_W-1:0]              sx_base_ff;
   logic [CNT_W-1:0]             row_ff;
   logic [CNT_W-1:0]             col_ff;
   logic [15:0]                  dest_x_ff;
   logic [15:0]                  dest_y_ff;
   logic                         mirror_x_ff;
   logic                         mirror_y_ff;
   logic                         use_ff;
   logic [tsb_pkg::INDEX_W-1:0]  ovr_ff;
   logic                         s1_valid_ff;
   logic                         s1_vis_ff;
   logic [tsb_pkg::COORD_W-1:0]  s1_px_ff;
   logic [tsb_pkg::COORD_W-1:0]  s1_py_ff;
   logic                         pend_valid_ff;
   tsb_pkg::rsp_type             pend_ff;
   logic                         rsp_valid_ff;
   tsb_pkg::rsp_type             rsp_data_ff;

   logic                         req_fire;
   logic                         advance;
   logic                         rd_en;
   logic                         cand;
   logic [24:0]                  recip_prod;
   logic [7:0]                   quo_in;
   logic [7:0]                   rem_wide;
   logic [6:0]                   rem_in;
   logic [tsb_pkg::INDEX_W-1:0]  rd_data;
   logic [tsb_pkg::INDEX_W-1:0]  lookup;
   logic [tsb_pkg::RGB_W-1:0]    rgb;
   tsb_pkg::walk_status_type     walk;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   // the walk moves only when the output slot is free or being taken
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign rd_en     = (state_ff == ST_WALK) && advance;
   assign cand      = s1_valid_ff && s1_vis_ff && (rd_data != '0);
   assign lookup    = use_ff ? ovr_ff : rd_data;

   // split the cell number by CELLS_PER_ROW with a reciprocal multiply
   always_comb begin
      recip_prod = 25'(dvd_ff) * 25'(DIV_MULT);
      quo_in     = recip_prod[DIV_SHIFT +: 8];
      rem_wide   = dvd_ff - 8'(32'(quo_in) * 32'(CELLS_PER_ROW));
      rem_in     = rem_wide[6:0];
   end

   tsb_sheet_ram u_sheet (
      .clock   (clock),
      .wr_en   (req_fire && (req_data.op == tsb_pkg::OP_LOAD)),
      .wr_addr (req_data.sheet_addr),
      .wr_data (req_data.sheet_pixel),
      .rd_en   (rd_en),
      .rd_addr (walk.addr),
      .rd_data (rd_data)
   );

   tsb_palette #(
      .PALETTE_SIZE (PALETTE_SIZE)
   ) u_palette (
      .clock      (clock),
      .reset      (reset),
      .set_en     (req_fire && (req_data.op == tsb_pkg::OP_PAL_SET)),
      .restore_en (req_fire && (req_data.op == tsb_pkg::OP_PAL_RESET)),
      .entry      (req_data.pal_entry),
      .source     (req_data.pal_source),
      .lookup     (lookup),
      .rgb        (rgb)
   );

   tsb_walk_unit #(
      .CELL_SIZE     (CELL_SIZE),
      .CELLS_PER_ROW (CELLS_PER_ROW),
      .CANVAS_WIDTH  (CANVAS_WIDTH),
      .CANVAS_HEIGHT (CANVAS_HEIGHT)
   ) u_walk (
      .sy_base  (sy_base_ff),
      .sx_base  (sx_base_ff),
      .row      (row_ff),
      .col      (col_ff),
      .mirror_x (mirror_x_ff),
      .mirror_y (mirror_y_ff),
      .dest_x   (dest_x_ff),
      .dest_y   (dest_y_ff),
      .status   (walk)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         row_ff        <= '0;
         col_ff        <= '0;
         s1_valid_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire && (req_data.op == tsb_pkg::OP_BLIT)) begin
                  dvd_ff      <= req_data.cell_index;
                  dest_x_ff   <= req_data.dest_x;
                  dest_y_ff   <= req_data.dest_y;
                  mirror_x_ff <= req_data.mirror_x;
                  mirror_y_ff <= req_data.mirror_y;
                  use_ff      <= req_data.use_colour;
                  ovr_ff      <= req_data.override_colour;
                  state_ff    <= ST_DIV;
               end
            end
            ST_DIV: begin
               quo_ff   <= quo_in;
               rem_ff   <= rem_in;
               state_ff <= ST_BASE;
            end
            ST_BASE: begin
               sy_base_ff <= SY_W'(32'(quo_ff) * 32'(CELL_SIZE));
               sx_base_ff <= SX_W'(32'(rem_ff) * 32'(CELL_SIZE));
               row_ff     <= '0;
               col_ff     <= '0;
               state_ff   <= ST_WALK;
            end
            ST_WALK: begin
               if (advance) begin
                  if (col_ff == CNT_W'(CELL_SIZE - 1)) begin
                     col_ff <= '0;
                     if (row_ff == CNT_W'(CELL_SIZE - 1)) begin
                        state_ff <= ST_DRAIN;
                     end else begin
                        row_ff <= row_ff + CNT_W'(1);
                     end
                  end else begin
                     col_ff <= col_ff + CNT_W'(1);
                  end
               end
            end
            ST_DRAIN: begin
               if (advance && !s1_valid_ff) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase

         // stage 1 follows the sheet read
         if (advance) begin
            s1_valid_ff <= (state_ff == ST_WALK);
            s1_vis_ff   <= walk.row_ok && walk.on_canvas;
            s1_px_ff    <= walk.px;
            s1_py_ff    <= walk.py;
         end

         // hold one pixel back so the final one can carry last
         if (advance) begin
            if (cand) begin
               pend_ff.pixel_x   <= s1_px_ff;
               pend_ff.pixel_y   <= s1_py_ff;
               pend_ff.pixel_rgb <= rgb;
               pend_ff.last      <= 1'b0;
               pend_valid_ff     <= 1'b1;
               rsp_valid_ff      <= pend_valid_ff;
               rsp_data_ff       <= pend_ff;
            end else if ((state_ff == ST_DRAIN) && !s1_valid_ff) begin
               rsp_valid_ff  <= pend_valid_ff;
               rsp_data_ff   <= '{pixel_x:   pend_ff.pixel_x,
                                  pixel_y:   pend_ff.pixel_y,
                                  pixel_rgb: pend_ff.pixel_rgb,
                                  last:      1'b1};
               pend_valid_ff <= 1'b0;
            end else begin
               rsp_valid_ff <= 1'b0;
            end
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // no walk data may remain once the sequencer is back in idle
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!s1_valid_ff && !pend_valid_ff))
      else $error("blit data left over in idle");

   // a result that is not the final one always has a successor held back
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.last) |-> pend_valid_ff)
      else $error("non-final result without a held pixel");

   // stage 1 is only live during the walk and its drain
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> ((state_ff == ST_WALK) || (state_ff == ST_DRAIN)))
      else $error("read stage valid outside of a blit");

endmodule

// File: tb/tile_sprite_blitter_tb.sv
// Self-checking testbench for tile_sprite_blitter: loads sheet cells, edits the palette
// and blits cells while a pixel ledger class predicts every painted pixel.
// Depends on tsb_pkg and the tile_sprite_blitter RTL.
`timescale 1ns / 1ps

module tile_sprite_blitter_tb;

   localparam int CELL       = tsb_pkg::CELL_SIZE_DEF;
   localparam int CELLS      = tsb_pkg::CELLS_PER_ROW_DEF;
   localparam int SHEET_COLS = tsb_pkg::CELL_SIZE_DEF * tsb_pkg::CELLS_PER_ROW_DEF;
   localparam int SHEET_ROWS = tsb_pkg::SHEET_DEPTH / SHEET_COLS;
   localparam int CANVAS_W   = tsb_pkg::CANVAS_WIDTH_DEF;
   localparam int CANVAS_H   = tsb_pkg::CANVAS_HEIGHT_DEF;
   localparam int PAL_COUNT  = tsb_pkg::PALETTE_SIZE_DEF;
   localparam int IDLE_LIMIT = 2000;
   localparam int RANDOM_ITEMS = 90;

   // Tracks sheet and palette contents and the pixels still owed by the block.
   class pixel_ledger;
      logic [tsb_pkg::INDEX_W-1:0] sheet[tsb_pkg::SHEET_DEPTH];
      logic [tsb_pkg::INDEX_W-1:0] palette[tsb_pkg::PAL_DEPTH];
      logic [tsb_pkg::RGB_W-1:0]   base_colour[16];
      tsb_pkg::rsp_type            due_pixels[$];
      int                          mismatches;

      function new();
         base_colour = '{24'h000000, 24'h1d2b53, 24'h7e2553, 24'h008751,
                         24'hab5236, 24'h5f574f, 24'hc2c3c7, 24'hfff1e8,
                         24'hff004d, 24'hffa300, 24'hffec27, 24'h00e436,
                         24'h29adff, 24'h83769c, 24'hff77a8, 24'hffccaa};
         for (int i = 0; i < tsb_pkg::PAL_DEPTH; i++) palette[i] = i[tsb_pkg::INDEX_W-1:0];
         for (int i = 0; i < tsb_pkg::SHEET_DEPTH; i++) sheet[i] = '0;
         mismatches = 0;
      endfunction

      function void apply_request(tsb_pkg::req_type r);
         int cx, cy, dx, dy, sy, sx, px, py;
         logic [tsb_pkg::INDEX_W-1:0] idx, ent;
         tsb_pkg::rsp_type pix, prev;
         bit held;
         held = 0;
         prev = '0;
         case (r.op)
            tsb_pkg::OP_LOAD: sheet[r.sheet_addr] = r.sheet_pixel;
            tsb_pkg::OP_PAL_SET: begin
               if (r.pal_entry < PAL_COUNT && r.pal_source < PAL_COUNT)
                  palette[r.pal_entry] = r.pal_source;
            end
            tsb_pkg::OP_PAL_RESET: begin
               for (int i = 0; i < tsb_pkg::PAL_DEPTH; i++)
                  palette[i] = i[tsb_pkg::INDEX_W-1:0];
            end
            default: begin
               cx = int'(r.cell_index) % CELLS;
               cy = int'(r.cell_index) / CELLS;
               dx = $signed(r.dest_x);
               dy = $signed(r.dest_y);
               for (int row = 0; row < CELL; row++) begin
                  sy = cy * CELL + row;
                  py = dy + (r.mirror_y ? CELL - 1 - row : row);
                  if (sy >= SHEET_ROWS) continue;
                  for (int col = 0; col < CELL; col++) begin
                     sx = cx * CELL + col;
                     px = dx + (r.mirror_x ? CELL - 1 - col : col);
                     if (sx >= SHEET_COLS) continue;
                     idx = sheet[sy * SHEET_COLS + sx];
                     if (idx == 0) continue;
                     if (px < 0 || py < 0 || px >= CANVAS_W || py >= CANVAS_H) continue;
                     ent = r.use_colour ? r.override_colour : idx;
                     pix.pixel_x   = px[tsb_pkg::COORD_W-1:0];
                     pix.pixel_y   = py[tsb_pkg::COORD_W-1:0];
                     pix.pixel_rgb = base_colour[palette[ent]];
                     pix.last      = 1'b0;
                     // hold one pixel back so the final one can carry last
                     if (held) due_pixels.push_back(prev);
                     prev = pix;
                     held = 1;
                  end
               end
               if (held) begin
                  prev.last = 1'b1;
                  due_pixels.push_back(prev);
               end
            end
         endcase
      endfunction

      function void compare_pixel(tsb_pkg::rsp_type got);
         tsb_pkg::rsp_type want;
         if (due_pixels.size() == 0) begin
            $error("unexpected pixel x=%0d y=%0d rgb=%06h last=%0d",
                   got.pixel_x, got.pixel_y, got.pixel_rgb, got.last);
            mismatches++;
            return;
         end
         want = due_pixels.pop_front();
         if (got.pixel_x !== want.pixel_x) begin
            $error("pixel_x: expected %0d, actual %0d", want.pixel_x, got.pixel_x);
            mismatches++;
         end
         if (got.pixel_y !== want.pixel_y) begin
            $error("pixel_y: expected %0d, actual %0d", want.pixel_y, got.pixel_y);
            mismatches++;
         end
         if (got.pixel_rgb !== want.pixel_rgb) begin
            $error("pixel_rgb: expected %06h, actual %06h", want.pixel_rgb, got.pixel_rgb);
            mismatches++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, got.last);
            mismatches++;
         end
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   tsb_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   tsb_pkg::rsp_type rsp_data;

   pixel_ledger book;
   bit          calm;
   int          sent;
   int          stall_left;
   int          idle_cycles;
   bit          cell_ready[256];
   int          ready_cells[$];

   tile_sprite_blitter uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // Result side: random stall bursts, no new burst started once calm
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 12);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) book.compare_pixel(rsp_data);
   end

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   function automatic tsb_pkg::req_type random_item();
      logic [95:0] raw;
      raw = {$urandom(), $urandom(), $urandom()};
      return raw[$bits(tsb_pkg::req_type)-1:0];
   endfunction

   function automatic logic [tsb_pkg::SHEET_ADDR_W-1:0] cell_addr(int cell_num, int k);
      int a;
      a = ((cell_num / CELLS) * CELL + k / CELL) * SHEET_COLS
          + (cell_num % CELLS) * CELL + k % CELL;
      return a[tsb_pkg::SHEET_ADDR_W-1:0];
   endfunction

   task automatic send_request(input tsb_pkg::req_type r);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_data  <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      book.apply_request(r);
      sent++;
   endtask

   task automatic load_pixel(input logic [tsb_pkg::SHEET_ADDR_W-1:0] addr,
                             input logic [3:0] pix);
      tsb_pkg::req_type r;
      r = random_item();
      r.op          = tsb_pkg::OP_LOAD;
      r.sheet_addr  = addr;
      r.sheet_pixel = pix;
      send_request(r);
   endtask

   task automatic set_entry(input logic [3:0] entry, input logic [3:0] source);
      tsb_pkg::req_type r;
      r = random_item();
      r.op         = tsb_pkg::OP_PAL_SET;
      r.pal_entry  = entry;
      r.pal_source = source;
      send_request(r);
   endtask

   task automatic reset_palette();
      tsb_pkg::req_type r;
      r = random_item();
      r.op = tsb_pkg::OP_PAL_RESET;
      send_request(r);
   endtask

   task automatic blit(input int cell_num, input int dx, input int dy, input bit mx,
                       input bit my, input bit use_ovr, input logic [3:0] ovr);
      tsb_pkg::req_type r;
      r = random_item();
      r.op              = tsb_pkg::OP_BLIT;
      r.cell_index      = cell_num[7:0];
      r.dest_x          = dx[15:0];
      r.dest_y          = dy[15:0];
      r.mirror_x        = mx;
      r.mirror_y        = my;
      r.use_colour      = use_ovr;
      r.override_colour = ovr;
      send_request(r);
   endtask

   // Write all pixels of one cell; a blank cell is fully transparent.
   task automatic fill_cell(input int cell_num, input bit blank);
      logic [3:0] pix;
      for (int k = 0; k < CELL * CELL; k++) begin
         if (blank || $urandom_range(0, 3) == 0) pix = 4'd0;
         else pix = 4'($urandom_range(1, 15));
         load_pixel(cell_addr(cell_num, k), pix);
      end
      if (!cell_ready[cell_num]) begin
         cell_ready[cell_num] = 1'b1;
         ready_cells.push_back(cell_num);
      end
   endtask

   initial begin : stimulus
      int base, choice, cell_num, dx, dy;
      bit paused;
      tsb_pkg::req_type r;
      clock       = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      calm        = 1'b0;
      sent        = 0;
      paused      = 0;
      book        = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // sheet setup: two corner cells and one transparent corner cell
      fill_cell(0, 0);
      fill_cell(255, 0);
      fill_cell(15, 1);

      // directed blits: clipping, mirrors, override colour, extremes and empty blits
      blit(0, 0, 0, 0, 0, 0, 4'd0);
      blit(255, 120, 120, 1, 0, 0, 4'd0);
      blit(0, -3, -5, 0, 1, 0, 4'd0);
      blit(255, 60, 30, 1, 1, 1, 4'd15);
      blit(0, -32768, -32768, 0, 0, 0, 4'd0);
      blit(255, 32767, 32767, 1, 1, 1, 4'd7);
      blit(15, 10, 10, 0, 0, 0, 4'd0);
      set_entry(4'd15, 4'd0);
      set_entry(4'd0, 4'd15);
      blit(0, 127, 127, 0, 0, 1, 4'd0);
      blit(255, -7, 127, 0, 0, 0, 4'd0);
      blit(255, 0, 0, 0, 0, 0, 4'd0);
      reset_palette();
      blit(0, 121, 0, 0, 0, 1, 4'd15);
      load_pixel(14'd16383, 4'd15);
      load_pixel(14'd0, 4'd0);
      blit(255, 120, 0, 1, 1, 0, 4'd0);
      blit(0, 0, 120, 0, 0, 0, 4'd0);

      base = sent;
      while (sent - base < RANDOM_ITEMS) begin
         if (!paused && sent - base >= RANDOM_ITEMS / 2) begin
            paused = 1;
            // hold off new requests until every owed pixel has drained
            if (book.due_pixels.size() != 0) begin
               req_valid <= 1'b0;
               while (book.due_pixels.size() != 0) @(posedge clock);
            end
         end
         calm     = (sent - base >= RANDOM_ITEMS * 4 / 5);
         choice   = $urandom_range(0, 99);
         cell_num = ready_cells[$urandom_range(0, ready_cells.size() - 1)];
         if (choice < 40) begin
            dx = $urandom_range(0, 140);
            dy = $urandom_range(0, 140);
            blit(cell_num, dx - 10, dy - 10, 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 4'($urandom_range(0, 15)));
         end else if (choice < 55) begin
            load_pixel(cell_addr(cell_num, $urandom_range(0, CELL * CELL - 1)),
                       4'($urandom_range(0, 15)));
         end else if (choice < 62) begin
            r = random_item();
            r.op = tsb_pkg::OP_LOAD;
            send_request(r);
         end else if (choice < 80) begin
            set_entry(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
         end else if (choice < 86) begin
            reset_palette();
         end else begin
            r = random_item();
            r.op         = tsb_pkg::OP_BLIT;
            r.cell_index = cell_num[7:0];
            send_request(r);
         end
      end

      req_valid <= 1'b0;
      while (book.due_pixels.size() != 0) @(posedge clock);
      // let a trailing empty blit run out before the final verdict
      repeat (100) @(posedge clock);
      if (book.mismatches == 0 && book.due_pixels.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/core/tsb_pkg.sv
rtl/core/tsb_sheet_ram.sv
rtl/core/tsb_palette.sv
rtl/core/tsb_walk_unit.sv
rtl/core/tile_sprite_blitter.sv
tb/tile_sprite_blitter_tb.sv
